### design/dkm_pkg.sv
// Shared types and constants of the k-mismatch DNA matcher.
package dkm_pkg;

	localparam int BASE_W = 2;
	localparam int IDX_W  = 8;
	localparam int LEN_W  = 9;
	localparam int LIM_W  = 8;
	localparam int POS_W  = 32;
	localparam int ERR_W  = 9;

	// Configuration port: data is as wide as the widest register.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LEN_W;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_LIMIT = 1'd1;

	// Input word kinds.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEXT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_COMPARE,
		ST_DONE
	} seq_state_t;

	// Control broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic              shift_text;
		logic              rot_win;
		logic              rot_pat;
		logic              load;
		logic [BASE_W-1:0] code;
	} cell_ctrl_t;

	typedef struct packed {
		logic              match_found;
		logic [POS_W-1:0]  end_position;
		logic [ERR_W-1:0]  mismatch_count;
		logic [POS_W-1:0]  occurrence_total;
	} out_word_t;

endpackage

### design/dkm_if.sv
// Valid/ready channel interfaces for input words and result words.
interface dkm_in_if;
	import dkm_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [BASE_W-1:0] base_code;
	logic [IDX_W-1:0]  pattern_index;
	logic              text_start;

	modport source (output valid, output action, output base_code,
		output pattern_index, output text_start, input ready);
	modport sink (input valid, input action, input base_code,
		input pattern_index, input text_start, output ready);
endinterface

interface dkm_out_if;
	import dkm_pkg::*;

	logic             valid;
	logic             ready;
	logic             match_found;
	logic [POS_W-1:0] end_position;
	logic [ERR_W-1:0] mismatch_count;
	logic [POS_W-1:0] occurrence_total;

	modport source (output valid, output match_found, output end_position,
		output mismatch_count, output occurrence_total, input ready);
	modport sink (input valid, input match_found, input end_position,
		input mismatch_count, input occurrence_total, output ready);
endinterface

### design/dkm_cell.sv
// One cell of the row: a pattern base and a text window base with neighbor links.
module dkm_cell (
	input  logic                               clk,
	input  dkm_pkg::cell_ctrl_t                ctrl,
	input  logic                               sel,
	input  logic [dkm_pkg::BASE_W-1:0]         win_below,
	input  logic [dkm_pkg::BASE_W-1:0]         win_above,
	input  logic [dkm_pkg::BASE_W-1:0]         pat_below,
	output logic [dkm_pkg::BASE_W-1:0]         win,
	output logic [dkm_pkg::BASE_W-1:0]         pat
);
	import dkm_pkg::*;

	logic [BASE_W-1:0] win_q;
	logic [BASE_W-1:0] pat_q;

	// Text bases move up the row on arrival; the scan rotates them back down.
	always_ff @(posedge clk) begin
		if (ctrl.shift_text) begin
			win_q <= win_below;
		end else if (ctrl.rot_win) begin
			win_q <= win_above;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			pat_q <= ctrl.code;
		end else if (ctrl.rot_pat) begin
			pat_q <= pat_below;
		end
	end

	assign win = win_q;
	assign pat = pat_q;

endmodule

### design/dkm_seq.sv
// Scan sequencer: text counters, mismatch accumulation and the result register.
module dkm_seq #(
	parameter int MAX_PATTERN = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              action,
	input  logic [dkm_pkg::BASE_W-1:0]        base_code,
	input  logic [dkm_pkg::IDX_W-1:0]         pattern_index,
	input  logic                              text_start,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]  m_eff,
	input  logic [dkm_pkg::LIM_W-1:0]         limit,
	input  logic                              mismatch,
	input  logic                              out_ready,
	output logic                              in_ready,
	output dkm_pkg::cell_ctrl_t               ctrl,
	output logic                              out_valid,
	output dkm_pkg::out_word_t                res
);
	import dkm_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PATTERN);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PATTERN - 1);

	seq_state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] fill_q;
	logic [POS_W-1:0] bases_q;
	logic [POS_W-1:0] matches_q;
	logic [POS_W-1:0] pos_q;
	logic [ERR_W-1:0] errs_q;
	logic             out_valid_q;
	out_word_t        res_q;

	logic             text_acc;
	logic [CNT_W-1:0] fill_base;
	logic [CNT_W-1:0] fill_new;
	logic [POS_W-1:0] bases_base;
	logic [CNT_W-1:0] align_last;
	logic             compare_on;
	logic             hit;
	logic [POS_W-1:0] occ_next;
	logic             res_load;

	assign text_acc   = accept && (action == ACT_TEXT);
	assign fill_base  = text_start ? '0 : fill_q;
	assign fill_new   = (fill_base != CNT_MAX) ? fill_base + CNT_W'(1) : fill_base;
	assign bases_base = text_start ? '0 : bases_q;

	// The pattern ring is turned MAX_PATTERN - m + 1 places before the
	// compare pass so that the two rings meet with the right offset.
	assign align_last = CNT_MAX - m_eff;
	assign compare_on = (state_q == ST_COMPARE) && (cnt_q < m_eff);

	assign hit      = errs_q <= {1'b0, limit};
	assign occ_next = (hit && (matches_q != '1)) ? matches_q + POS_W'(1) : matches_q;
	assign res_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (text_acc && (fill_new >= m_eff)) begin
					state_d = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (cnt_q == align_last) begin
					state_d = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ST_IDLE);
		ctrl.shift_text = text_acc;
		ctrl.load       = accept && (action == ACT_LOAD)
			&& (32'(pattern_index) < MAX_PATTERN);
		ctrl.code       = base_code;
		ctrl.rot_win    = (state_q == ST_COMPARE);
		ctrl.rot_pat    = (state_q == ST_ALIGN)
			|| ((state_q == ST_COMPARE) && ((cnt_q + CNT_W'(1)) < m_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == ST_ALIGN || state_q == ST_COMPARE) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			bases_q   <= '0;
			matches_q <= '0;
		end else begin
			if (text_acc) begin
				fill_q  <= fill_new;
				bases_q <= bases_base + POS_W'(1);
				if (text_start) begin
					matches_q <= '0;
				end
			end else if (res_load) begin
				matches_q <= occ_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_acc) begin
			pos_q  <= bases_base;
			errs_q <= '0;
		end else if (compare_on && mismatch && hit) begin
			errs_q <= errs_q + ERR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.match_found      <= hit;
			res_q.end_position     <= pos_q;
			res_q.mismatch_count   <= errs_q;
			res_q.occurrence_total <= occ_next;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

### design/dna_k_mismatch_matcher_core.sv
// Top level of the k-mismatch DNA matcher: configuration, cell row and sequencer.
// A pattern load, or a text word that does not yet close a full window, keeps ready up.
// A text word closing a window of m bases holds the input while the pattern ring and
// the window ring rotate through cell zero, until the result word is written into an
// output register, where it waits.
// Reset clears the counters, the fill count and the state; the stores are undefined.
module dna_k_mismatch_matcher_core #(
	parameter int MAX_PATTERN = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	dkm_in_if.sink                               item,
	dkm_out_if.source                            result,
	input  logic                                 cfg_wr_en,
	input  logic [dkm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dkm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import dkm_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	// Configuration registers (no guard in the block): the user must see they are written
	// only while the block is idle, so the scan sees stable values for the whole of a word.
	logic [LEN_W-1:0] len_q;
	logic [LIM_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_W'(1);
			limit_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: len_q   <= cfg_data;
				REG_MISMATCH_LIMIT: limit_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective pattern length: zero acts as one, and anything past the
	// row length is clipped to the row length.
	logic [CNT_W-1:0] m_eff;

	always_comb begin
		if (len_q == '0) begin
			m_eff = CNT_W'(1);
		end else if (32'(len_q) > MAX_PATTERN) begin
			m_eff = CNT_W'(MAX_PATTERN);
		end else begin
			m_eff = CNT_W'(len_q);
		end
	end

	// The row of cells. Cell j of the window holds the base j places back
	// once the word has been taken; a scan rotates the window down the row
	// one place per cycle and the pattern up the row, so that cell zero
	// sees each aligned pair of bases in turn and both rings end where
	// they started.
	cell_ctrl_t        ctrl;
	logic              accept;
	logic              mismatch;
	logic [BASE_W-1:0] win [MAX_PATTERN];
	logic [BASE_W-1:0] pat [MAX_PATTERN];

	assign accept   = item.valid && item.ready;
	assign mismatch = (win[0] != pat[0]);

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_row
		localparam int UP   = (j + 1) % MAX_PATTERN;
		localparam int DOWN = (j + MAX_PATTERN - 1) % MAX_PATTERN;

		logic              sel;
		logic [BASE_W-1:0] win_below;

		// Pattern loads write the one cell whose place matches the index.
		assign sel       = (32'(item.pattern_index) == 32'(j));
		assign win_below = (j == 0) ? ctrl.code : win[DOWN];

		dkm_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.sel       (sel),
			.win_below (win_below),
			.win_above (win[UP]),
			.pat_below (pat[DOWN]),
			.win       (win[j]),
			.pat       (pat[j])
		);
	end

	// Sequencer: text position and occurrence counters, the scan phases and
	// the result register that parts the scan from the output channel.
	out_word_t res;

	dkm_seq #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.action        (item.action),
		.base_code     (item.base_code),
		.pattern_index (item.pattern_index),
		.text_start    (item.text_start),
		.m_eff         (m_eff),
		.limit         (limit_q),
		.mismatch      (mismatch),
		.out_ready     (result.ready),
		.in_ready      (item.ready),
		.ctrl          (ctrl),
		.out_valid     (result.valid),
		.res           (res)
	);

	assign result.match_found      = res.match_found;
	assign result.end_position     = res.end_position;
	assign result.mismatch_count   = res.mismatch_count;
	assign result.occurrence_total = res.occurrence_total;

`ifndef SYNTHESIS
	// A result word only shows up after a scan during which input was held off.
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!item.ready))
		else $error("result word appeared without a preceding scan");

	// A pattern load never starts a scan.
	a_load_stays_free: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && (item.action == ACT_LOAD)) |=> item.ready)
		else $error("pattern load left the block busy");

	// The match flag agrees with the saturated mismatch count and the limit.
	a_count_vs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.match_found == (result.mismatch_count <= {1'b0, limit_q}))
			&& (result.mismatch_count <= ({1'b0, limit_q} + ERR_W'(1)))))
		else $error("match flag or mismatch count out of line with the limit");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the k-mismatch DNA matcher core.
module testbench;
	import dkm_pkg::*;

	localparam int DEPTH = 256;
	// Pattern entries written before any text; no test length goes past this.
	localparam int FILL_DEPTH = 32;
	// A window-closing text word holds the input for the whole of its scan, and its
	// result word follows. This wait is enough for the block to go quiet after the
	// last expected result.
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	// Receiver hold-off long enough to back the block up into its input.
	localparam int LONG_HOLD = 2500;

	// Scoreboard: keeps its own copy of the pattern, the text window, the
	// position and match counters and both registers. Every accepted word is
	// run through that copy, and each predicted result word is queued until
	// the block produces it.
	class alignment_scoreboard;
		logic [BASE_W-1:0] pattern_mem [DEPTH];
		logic [BASE_W-1:0] window_mem [DEPTH];
		logic [POS_W-1:0]  text_pos;
		logic [POS_W-1:0]  hit_total;
		int unsigned       slot;
		int unsigned       filled;
		logic [LEN_W-1:0]  length_reg;
		logic [LIM_W-1:0]  limit_reg;
		out_word_t         expected_hits [$];
		int unsigned       errors;

		function new();
			text_pos = '0;
			hit_total = '0;
			slot = 0;
			filled = 0;
			length_reg = LEN_W'(1);
			limit_reg = '0;
			errors = 0;
		endfunction

		// Pattern length actually compared: zero acts as one, oversize as the store depth.
		function int unsigned span();
			if (length_reg == 0)
				return 1;
			if (length_reg > DEPTH)
				return DEPTH;
			return length_reg;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_PATTERN_LENGTH)
				length_reg = value[LEN_W-1:0];
			else
				limit_reg = value[LIM_W-1:0];
		endfunction

		function void note_word(logic act, logic [BASE_W-1:0] code, logic [IDX_W-1:0] idx,
				logic start);
			int unsigned cur, m, k, errs, back;
			logic [POS_W-1:0] pos;
			out_word_t w;
			if (act == ACT_LOAD) begin
				pattern_mem[idx] = code;
				return;
			end
			if (start) begin
				text_pos = '0;
				hit_total = '0;
				slot = 0;
				filled = 0;
			end
			cur = slot;
			window_mem[cur] = code;
			slot = (cur + 1 == DEPTH) ? 0 : cur + 1;
			if (filled < DEPTH)
				filled++;
			pos = text_pos;
			text_pos = text_pos + 1;
			m = span();
			if (filled < m)
				return;
			k = limit_reg;
			errs = 0;
			// Pattern base i lines up with the text base m-1-i places back;
			// counting stops one past the limit.
			for (int unsigned i = 0; i < m && errs <= k; i++) begin
				back = m - 1 - i;
				if (window_mem[(cur + DEPTH - back) % DEPTH] !== pattern_mem[i])
					errs++;
			end
			w.match_found = (errs <= k);
			if (w.match_found && hit_total != '1)
				hit_total++;
			w.end_position = pos;
			w.mismatch_count = errs[ERR_W-1:0];
			w.occurrence_total = hit_total;
			expected_hits.push_back(w);
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (expected_hits.size() == 0) begin
				$display("%0t: result word expected none, got position %0d count %0d",
					$time, got.end_position, got.mismatch_count);
				errors++;
				return;
			end
			want = expected_hits.pop_front();
			if (got.match_found !== want.match_found) begin
				$display("%0t: match_found expected %0d, got %0d",
					$time, want.match_found, got.match_found);
				errors++;
			end
			if (got.end_position !== want.end_position) begin
				$display("%0t: end_position expected %0d, got %0d",
					$time, want.end_position, got.end_position);
				errors++;
			end
			if (got.mismatch_count !== want.mismatch_count) begin
				$display("%0t: mismatch_count expected %0d, got %0d",
					$time, want.mismatch_count, got.mismatch_count);
				errors++;
			end
			if (got.occurrence_total !== want.occurrence_total) begin
				$display("%0t: occurrence_total expected %0d, got %0d",
					$time, want.occurrence_total, got.occurrence_total);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dkm_in_if  item_ch ();
	dkm_out_if result_ch ();

	alignment_scoreboard board;

	// Set for the final phase: from then on neither side inserts idle cycles.
	bit                last_stretch = 1'b0;
	bit                long_hold_done = 1'b0;
	int unsigned       results_seen = 0;
	// Text bases planned for the current phase, consumed one per text word.
	logic [BASE_W-1:0] upcoming [$];

	dna_k_mismatch_matcher_core #(
		.MAX_PATTERN(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one input word, possibly after a short idle burst, and hold it until
	// the block takes it. The scoreboard sees the word at the accepting edge.
	task automatic send_word(input logic act, input logic [BASE_W-1:0] code,
			input logic [IDX_W-1:0] idx, input logic start);
		if (!last_stretch && $urandom_range(0, 99) < 25) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.base_code <= code;
		item_ch.pattern_index <= idx;
		item_ch.text_start <= start;
		do @(posedge clk); while (!item_ch.ready);
		board.note_word(act, code, idx, start);
	endtask

	// Stop offering, wait for every predicted result, then give the block time to
	// finish any word that produces no result.
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (board.expected_hits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Registers are only written with the block idle.
	task automatic configure(input logic [LEN_W-1:0] len_val, input logic [LIM_W-1:0] lim_val);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data <= CFG_DATA_W'(len_val);
		@(posedge clk);
		board.set_register(REG_PATTERN_LENGTH, CFG_DATA_W'(len_val));
		cfg_index <= REG_MISMATCH_LIMIT;
		cfg_data <= CFG_DATA_W'(lim_val);
		@(posedge clk);
		board.set_register(REG_MISMATCH_LIMIT, CFG_DATA_W'(lim_val));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// One random phase. The text is mostly copies of the pattern in use with a
	// few bases changed, so windows land on both sides of the limit, mixed with
	// short runs of random bases. A few pattern rewrites are sprinkled in.
	task automatic text_phase(input logic [LEN_W-1:0] len_val, input logic [LIM_W-1:0] lim_val,
			input int count, input bit fresh_text);
		int unsigned span_now, flips, spot;
		bit first;
		logic [BASE_W-1:0] b;
		logic [IDX_W-1:0] idx;
		configure(len_val, lim_val);
		span_now = board.span();
		upcoming.delete();
		first = fresh_text;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 8) begin
				// Rewrites mostly land inside the part of the pattern in use.
				if ($urandom_range(0, 1))
					idx = IDX_W'($urandom_range(0, span_now - 1));
				else
					idx = IDX_W'($urandom_range(0, DEPTH - 1));
				send_word(ACT_LOAD, BASE_W'($urandom_range(0, 3)), idx,
					1'($urandom_range(0, 1)));
				continue;
			end
			if (upcoming.size() == 0) begin
				if (first || $urandom_range(0, 1)) begin
					for (int i = 0; i < span_now; i++)
						upcoming.push_back(board.pattern_mem[i]);
					flips = $urandom_range(0, (lim_val < 4) ? lim_val + 1 : 5);
					repeat (flips) begin
						spot = $urandom_range(0, span_now - 1);
						upcoming[spot] = upcoming[spot] + BASE_W'($urandom_range(1, 3));
					end
				end else begin
					repeat ($urandom_range(1, (span_now < 8) ? span_now : 8))
						upcoming.push_back(BASE_W'($urandom_range(0, 3)));
				end
			end
			b = upcoming.pop_front();
			// Restarts are kept to patterns of at most 32 bases, where they do not starve the results.
			send_word(ACT_TEXT, b, IDX_W'($urandom),
				first || (span_now <= 32 && $urandom_range(0, 99) < 3));
			first = 1'b0;
		end
	endtask

	// Main stimulus.
	initial begin
		board = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACT_TEXT;
		item_ch.base_code <= '0;
		item_ch.pattern_index <= '0;
		item_ch.text_start <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the part of the pattern store that the test lengths reach, so
		// that no compare ever reads an entry that was never written.
		for (int i = 0; i < FILL_DEPTH; i++)
			send_word(ACT_LOAD, BASE_W'($urandom_range(0, 3)), IDX_W'(i), 1'b0);

		// Reset settings (length one, limit zero). The text starts without a
		// start mark and must continue from the reset state; every code appears.
		for (int c = 0; c < 4; c++)
			send_word(ACT_TEXT, BASE_W'(c), '0, 1'b0);
		// A load in the middle of a text leaves the position and counts alone.
		send_word(ACT_LOAD, 2'd3, '0, 1'b1);
		send_word(ACT_TEXT, 2'd3, '1, 1'b0);
		send_word(ACT_TEXT, 2'd0, '0, 1'b0);
		send_word(ACT_LOAD, 2'd2, '1, 1'b0);
		// A start mark clears the position and the match count.
		send_word(ACT_TEXT, 2'd3, '0, 1'b1);

		// Length zero behaves as length one; the largest limit matches everything.
		configure(LEN_W'(0), LIM_W'(255));
		send_word(ACT_TEXT, 2'd1, '1, 1'b1);
		send_word(ACT_TEXT, 2'd2, '0, 1'b0);

		// Length two: the first base of a text is too short for a window, the
		// second closes an exact match, then a mismatch saturates at one.
		configure(LEN_W'(2), LIM_W'(0));
		send_word(ACT_TEXT, board.pattern_mem[0], '0, 1'b1);
		send_word(ACT_TEXT, board.pattern_mem[1], '0, 1'b0);
		send_word(ACT_TEXT, ~board.pattern_mem[0], '0, 1'b0);
		send_word(ACT_TEXT, board.pattern_mem[1], '0, 1'b0);

		text_phase(LEN_W'(3), LIM_W'(0), 60, 1'b1);
		text_phase(LEN_W'(8), LIM_W'(2), 70, 1'b0);
		// Longest pattern of the run: a fresh text must see 32 bases before any result.
		text_phase(LEN_W'(32), LIM_W'(6), 100, 1'b1);
		text_phase(LEN_W'(20), LIM_W'(4), 60, 1'b1);
		last_stretch = 1'b1;
		text_phase(LEN_W'(6), LIM_W'(1), 50, 1'b0);

		settle();
		if (board.errors == 0 && board.expected_hits.size() == 0) begin
			$display("dna_k_mismatch_matcher_core test passed");
		end else begin
			$display("dna_k_mismatch_matcher_core test failed");
		end
		$finish;
	end

	// Result side: check each accepted word and stall at random. Once, after a
	// few dozen results, hold off long enough that the output register stays
	// full and the block stops taking input words.
	initial begin
		int unsigned hold;
		out_word_t got;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.match_found = result_ch.match_found;
				got.end_position = result_ch.end_position;
				got.mismatch_count = result_ch.mismatch_count;
				got.occurrence_total = result_ch.occurrence_total;
				board.check_result(got);
				results_seen++;
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 40) begin
				long_hold_done = 1'b1;
				hold = LONG_HOLD - 1;
				result_ch.ready <= 1'b0;
			end else if (!last_stretch && $urandom_range(0, 99) < 12) begin
				hold = $urandom_range(0, 5);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a correct run takes well under a third of this.
	initial begin
		#5_000_000;
		$display("dna_k_mismatch_matcher_core test failed");
		$finish;
	end

endmodule
